// ===== design/lnsa_pkg.sv =====
// Shared constants for the letterbox nearest-neighbour scaler address unit.
package lnsa_pkg;

    localparam int SURF_REG_W = 15;
    localparam int SRC_REG_W  = 13;
    localparam int COORD_W    = 14;
    localparam int SRC_OUT_W  = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam int DEF_MAX_SURFACE = 16384;
    localparam int DEF_MAX_SOURCE  = 4096;

    localparam int GAP_DIV = 40;
    localparam int GAP_MIN = 24;

    // Width/40 as a shift by 3, then x/5 as x*52429 >> 18 (exact below 2^16)
    localparam int GAP_PRE_SHIFT  = 3;
    localparam int GAP_RECIP      = 52429;
    localparam int GAP_POST_SHIFT = 18;

    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUAL_PANES     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGER_SCALE  = 3'd5;

    localparam logic [SURF_REG_W-1:0] RST_SURFACE_WIDTH  = 15'd640;
    localparam logic [SURF_REG_W-1:0] RST_SURFACE_HEIGHT = 15'd480;
    localparam logic [SRC_REG_W-1:0]  RST_SOURCE_WIDTH   = 13'd320;
    localparam logic [SRC_REG_W-1:0]  RST_SOURCE_HEIGHT  = 13'd240;

endpackage

// ===== design/lnsa_divstep.sv =====
// One restoring division stage of the per-pixel pipeline: one quotient bit for x and y.
module lnsa_divstep #(
    parameter int DW  = 15,
    parameter int PRW = 28,
    parameter int QW  = 12,
    parameter int BIT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_v,
    input  logic           i_hit,
    input  logic           i_pane,
    input  logic [PRW-1:0] i_nx,
    input  logic [QW-1:0]  i_qx,
    input  logic [DW-1:0]  i_cw,
    input  logic [PRW-1:0] i_ny,
    input  logic [QW-1:0]  i_qy,
    input  logic [DW-1:0]  i_ch,
    output logic           o_v,
    output logic           o_hit,
    output logic           o_pane,
    output logic [PRW-1:0] o_nx,
    output logic [QW-1:0]  o_qx,
    output logic [DW-1:0]  o_cw,
    output logic [PRW-1:0] o_ny,
    output logic [QW-1:0]  o_qy,
    output logic [DW-1:0]  o_ch
);

    logic [PRW-1:0] w_dx;
    logic [PRW-1:0] w_dy;
    logic           w_gex;
    logic           w_gey;
    logic           r_v;
    logic           r_hit;
    logic           r_pane;
    logic [PRW-1:0] r_nx;
    logic [QW-1:0]  r_qx;
    logic [DW-1:0]  r_cw;
    logic [PRW-1:0] r_ny;
    logic [QW-1:0]  r_qy;
    logic [DW-1:0]  r_ch;

    assign w_dx  = PRW'(i_cw) << BIT;
    assign w_dy  = PRW'(i_ch) << BIT;
    assign w_gex = (i_nx >= w_dx);
    assign w_gey = (i_ny >= w_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit  <= i_hit;
            r_pane <= i_pane;
            r_nx   <= w_gex ? (i_nx - w_dx) : i_nx;
            r_qx   <= i_qx | (QW'(w_gex) << BIT);
            r_cw   <= i_cw;
            r_ny   <= w_gey ? (i_ny - w_dy) : i_ny;
            r_qy   <= i_qy | (QW'(w_gey) << BIT);
            r_ch   <= i_ch;
        end
    end

    assign o_v    = r_v;
    assign o_hit  = r_hit;
    assign o_pane = r_pane;
    assign o_nx   = r_nx;
    assign o_qx   = r_qx;
    assign o_cw   = r_cw;
    assign o_ny   = r_ny;
    assign o_qy   = r_qy;
    assign o_ch   = r_ch;

endmodule

// ===== design/lnsa_setup.sv =====
// Configuration registers and the sequential geometry engine that fits the panes.
module lnsa_setup #(
    parameter int MAX_SURFACE = 16384,
    parameter int MAX_SOURCE  = 4096,
    parameter int DW          = 15,
    parameter int SWD         = 13
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lnsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lnsa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_busy,
    output logic [SWD-1:0]                 o_iw,
    output logic [SWD-1:0]                 o_ih,
    output logic                           o_en [2],
    output logic [DW-1:0]                  o_x0 [2],
    output logic [DW-1:0]                  o_cw [2],
    output logic [DW-1:0]                  o_y0 [2],
    output logic [DW-1:0]                  o_ch [2]
);
    import lnsa_pkg::*;

    localparam int PRW  = DW + SWD;
    localparam int DVS  = (DW > SWD) ? DW : SWD;
    localparam int CNTW = $clog2(PRW + 1);
    localparam int GW   = DW + 2;
    localparam int GQW  = DW + 16;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_GAP  = 4'd1;
    localparam logic [3:0] ST_MUL1 = 4'd2;
    localparam logic [3:0] ST_MUL2 = 4'd3;
    localparam logic [3:0] ST_DIVA = 4'd4;
    localparam logic [3:0] ST_DIVB = 4'd5;
    localparam logic [3:0] ST_DIVF = 4'd6;
    localparam logic [3:0] ST_MUL3 = 4'd7;
    localparam logic [3:0] ST_MUL4 = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;

    logic [SURF_REG_W-1:0] r_sw_reg;
    logic [SURF_REG_W-1:0] r_sh_reg;
    logic [SRC_REG_W-1:0]  r_iw_reg;
    logic [SRC_REG_W-1:0]  r_ih_reg;
    logic                  r_dual;
    logic                  r_intg;

    logic [3:0]      r_st;
    logic            r_pane;
    logic            r_drun;
    logic [CNTW-1:0] r_dcnt;
    logic [DVS-1:0]  r_drem;
    logic [PRW-1:0]  r_dq;
    logic [DVS-1:0]  r_dv;

    logic [DW-1:0]  r_gap;
    logic [PRW-1:0] r_p1;
    logic [PRW-1:0] r_p2;
    logic [PRW-1:0] r_t1;
    logic [PRW-1:0] r_t2;
    logic [DW-1:0]  r_qa;
    logic [DW-1:0]  r_qb;
    logic [DW-1:0]  r_qf;

    logic           r_en [2];
    logic [DW-1:0]  r_x0 [2];
    logic [DW-1:0]  r_cw [2];
    logic [DW-1:0]  r_y0 [2];
    logic [DW-1:0]  r_ch [2];

    logic [DW-1:0]   w_sw;
    logic [DW-1:0]   w_sh;
    logic [SWD-1:0]  w_iw;
    logic [SWD-1:0]  w_ih;
    logic            w_gvalid;
    logic [GQW-1:0]  w_gprod;
    logic [DW-1:0]   w_gap;
    logic signed [GW-1:0] w_t;
    logic signed [GW-1:0] w_lw;
    logic signed [GW-1:0] w_pw1;
    logic            w_ok;
    logic [DW-1:0]   w_pw;
    logic [DW-1:0]   w_px;
    logic            w_wide;
    logic [DW-1:0]   w_s;
    logic [DW-1:0]   w_ma;
    logic [SWD-1:0]  w_mb;
    logic [PRW-1:0]  w_prod;
    logic            w_in_div;
    logic            w_dload;
    logic            w_ddone;
    logic [PRW-1:0]  w_dd;
    logic [DVS-1:0]  w_dvin;
    logic [DVS:0]    w_rsh;
    logic            w_dge;
    logic [DW-1:0]   w_cw;
    logic [DW-1:0]   w_ch;
    logic            w_fen;
    logic [DW-1:0]   w_x0;
    logic [DW-1:0]   w_y0;

    // Oversized registers saturate to the supported maximum
    assign w_sw = (32'(r_sw_reg) > 32'(MAX_SURFACE)) ? DW'(MAX_SURFACE) : DW'(r_sw_reg);
    assign w_sh = (32'(r_sh_reg) > 32'(MAX_SURFACE)) ? DW'(MAX_SURFACE) : DW'(r_sh_reg);
    assign w_iw = (32'(r_iw_reg) > 32'(MAX_SOURCE)) ? SWD'(MAX_SOURCE) : SWD'(r_iw_reg);
    assign w_ih = (32'(r_ih_reg) > 32'(MAX_SOURCE)) ? SWD'(MAX_SOURCE) : SWD'(r_ih_reg);
    assign w_gvalid = (w_sw != '0) && (w_sh != '0) && (w_iw != '0) && (w_ih != '0);

    // Gap quotient by reciprocal multiply
    assign w_gprod = GQW'(w_sw >> GAP_PRE_SHIFT) * GQW'(GAP_RECIP);

    // Pane split: left width (sw-gap)/2 clamped to [1, sw-1], right takes the rest
    always_comb begin
        w_gap = (r_gap < DW'(GAP_MIN)) ? DW'(GAP_MIN) : r_gap;
        w_t   = $signed({2'b00, w_sw}) - $signed({2'b00, w_gap});
        w_lw  = (w_t > 0) ? (w_t >>> 1) : '0;
        if (w_lw > $signed({2'b00, w_sw}) - GW'(1)) begin
            w_lw = $signed({2'b00, w_sw}) - GW'(1);
        end
        if (w_lw < GW'(1)) begin
            w_lw = GW'(1);
        end
        w_pw1 = $signed({2'b00, w_sw}) - w_lw - $signed({2'b00, w_gap});
        if (!r_dual) begin
            w_ok = !r_pane;
            w_pw = w_sw;
            w_px = '0;
        end else if (!r_pane) begin
            w_ok = (w_sw >= DW'(2));
            w_pw = DW'(w_lw);
            w_px = '0;
        end else begin
            w_ok = (w_sw >= DW'(2)) && (w_pw1 > 0);
            w_pw = DW'(w_pw1);
            w_px = DW'(w_lw + $signed({2'b00, w_gap}));
        end
    end

    assign w_wide = (r_p1 > r_p2);
    assign w_s    = (r_qa < r_qb) ? r_qa : r_qb;

    // Shared multiplier
    always_comb begin
        case (r_st)
            ST_MUL1: begin
                w_ma = w_pw;
                w_mb = w_ih;
            end
            ST_MUL2: begin
                w_ma = w_sh;
                w_mb = w_iw;
            end
            ST_MUL3: begin
                w_ma = w_s;
                w_mb = w_iw;
            end
            ST_MUL4: begin
                w_ma = w_s;
                w_mb = w_ih;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_prod = {{SWD{1'b0}}, w_ma} * {{DW{1'b0}}, w_mb};

    // Shared divider operands
    always_comb begin
        case (r_st)
            ST_DIVA: begin
                w_dd   = PRW'(w_pw);
                w_dvin = DVS'(w_iw);
            end
            ST_DIVB: begin
                w_dd   = PRW'(w_sh);
                w_dvin = DVS'(w_ih);
            end
            ST_DIVF: begin
                w_dd   = w_wide ? r_p2 : r_p1;
                w_dvin = w_wide ? DVS'(w_ih) : DVS'(w_iw);
            end
            default: begin
                w_dd   = '0;
                w_dvin = '0;
            end
        endcase
    end

    assign w_in_div = (r_st == ST_DIVA) || (r_st == ST_DIVB) || (r_st == ST_DIVF);
    assign w_dload  = w_in_div && !r_drun && !i_cfg_we;
    assign w_ddone  = r_drun && (r_dcnt == '0);
    assign w_rsh    = {r_drem, r_dq[PRW-1]};
    assign w_dge    = (w_rsh >= {1'b0, r_dv});

    // One quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (w_dload) begin
            r_drem <= '0;
            r_dq   <= w_dd;
            r_dv   <= w_dvin;
            r_dcnt <= CNTW'(PRW);
        end else if (r_dcnt != '0) begin
            r_drem <= w_dge ? DVS'(w_rsh - {1'b0, r_dv}) : w_rsh[DVS-1:0];
            r_dq   <= {r_dq[PRW-2:0], w_dge};
            r_dcnt <= r_dcnt - CNTW'(1);
        end
    end

    // Fitted size and centring of the current pane
    always_comb begin
        if (r_intg) begin
            if (w_s != '0) begin
                w_cw = DW'(r_t1);
                w_ch = DW'(r_t2);
            end else begin
                w_cw = w_pw;
                w_ch = w_sh;
            end
        end else if (w_wide) begin
            w_cw = r_qf;
            w_ch = w_sh;
        end else begin
            w_cw = w_pw;
            w_ch = r_qf;
        end
        w_fen = w_gvalid && w_ok && (w_cw != '0) && (w_ch != '0);
        w_x0  = w_px + ((w_pw - w_cw) >> 1);
        w_y0  = (w_sh - w_ch) >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_reg <= RST_SURFACE_WIDTH;
            r_sh_reg <= RST_SURFACE_HEIGHT;
            r_iw_reg <= RST_SOURCE_WIDTH;
            r_ih_reg <= RST_SOURCE_HEIGHT;
            r_dual   <= 1'b0;
            r_intg   <= 1'b0;
            r_st     <= ST_GAP;
            r_pane   <= 1'b0;
            r_drun   <= 1'b0;
            r_en[0]  <= 1'b0;
            r_en[1]  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SURFACE_WIDTH:  r_sw_reg <= i_cfg_data[SURF_REG_W-1:0];
                REG_SURFACE_HEIGHT: r_sh_reg <= i_cfg_data[SURF_REG_W-1:0];
                REG_SOURCE_WIDTH:   r_iw_reg <= i_cfg_data[SRC_REG_W-1:0];
                REG_SOURCE_HEIGHT:  r_ih_reg <= i_cfg_data[SRC_REG_W-1:0];
                REG_DUAL_PANES:     r_dual   <= i_cfg_data[0];
                REG_INTEGER_SCALE:  r_intg   <= i_cfg_data[0];
                default: ;
            endcase
            r_st   <= ST_GAP;
            r_pane <= 1'b0;
            r_drun <= 1'b0;
        end else begin
            case (r_st)
                ST_IDLE: ;
                ST_GAP: begin
                    r_gap <= DW'(w_gprod >> GAP_POST_SHIFT);
                    r_st  <= ST_MUL1;
                end
                ST_MUL1: begin
                    r_p1 <= w_prod;
                    r_st <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_p2 <= w_prod;
                    r_st <= ST_DIVA;
                end
                ST_DIVA: begin
                    if (w_ddone) begin
                        r_qa   <= DW'(r_dq);
                        r_drun <= 1'b0;
                        r_st   <= ST_DIVB;
                    end else if (!r_drun) begin
                        r_drun <= 1'b1;
                    end
                end
                ST_DIVB: begin
                    if (w_ddone) begin
                        r_qb   <= DW'(r_dq);
                        r_drun <= 1'b0;
                        r_st   <= ST_DIVF;
                    end else if (!r_drun) begin
                        r_drun <= 1'b1;
                    end
                end
                ST_DIVF: begin
                    if (w_ddone) begin
                        r_qf   <= DW'(r_dq);
                        r_drun <= 1'b0;
                        r_st   <= ST_MUL3;
                    end else if (!r_drun) begin
                        r_drun <= 1'b1;
                    end
                end
                ST_MUL3: begin
                    r_t1 <= w_prod;
                    r_st <= ST_MUL4;
                end
                ST_MUL4: begin
                    r_t2 <= w_prod;
                    r_st <= ST_FIN;
                end
                ST_FIN: begin
                    r_en[r_pane] <= w_fen;
                    r_x0[r_pane] <= w_x0;
                    r_cw[r_pane] <= w_cw;
                    r_y0[r_pane] <= w_y0;
                    r_ch[r_pane] <= w_ch;
                    if (!r_pane) begin
                        r_pane <= 1'b1;
                        r_st   <= ST_MUL1;
                    end else begin
                        r_st   <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_busy = (r_st != ST_IDLE);
    assign o_iw   = w_iw;
    assign o_ih   = w_ih;
    assign o_en   = r_en;
    assign o_x0   = r_x0;
    assign o_cw   = r_cw;
    assign o_y0   = r_y0;
    assign o_ch   = r_ch;

endmodule

// ===== design/letterbox_nearest_scaler_address.sv =====
// Top level: per-pixel letterbox hit test and nearest source address pipeline.
//
// One output pixel coordinate is taken per clock while the output is not
// stalled and the geometry engine is idle. Its result word passes through
// a pane test stage, a multiply stage, one restoring division stage per
// source address bit, and the output register. A stalled output holds
// the whole pipeline. Pane geometry is worked out by a sequential engine
// with one shared multiplier and a one-bit-a-cycle divider; it runs after
// reset and after every register write, and no word is taken while it runs.
module letterbox_nearest_scaler_address #(
    parameter int MAX_SURFACE = lnsa_pkg::DEF_MAX_SURFACE,
    parameter int MAX_SOURCE  = lnsa_pkg::DEF_MAX_SOURCE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lnsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lnsa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [lnsa_pkg::COORD_W-1:0]    i_out_x,
    input  logic [lnsa_pkg::COORD_W-1:0]    i_out_y,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_inside_res,
    output logic                           o_pane_index,
    output logic [lnsa_pkg::SRC_OUT_W-1:0]  o_src_x,
    output logic [lnsa_pkg::SRC_OUT_W-1:0]  o_src_y
);
    import lnsa_pkg::*;

    localparam int DW  = $clog2(MAX_SURFACE + 1);
    localparam int SWD = $clog2(MAX_SOURCE + 1);
    localparam int PRW = DW + SWD;
    localparam int QW  = $clog2(MAX_SOURCE);
    localparam int XW  = ((COORD_W > DW) ? COORD_W : DW) + 1;

    logic           w_busy;
    logic [SWD-1:0] w_iw;
    logic [SWD-1:0] w_ih;
    logic           w_en [2];
    logic [DW-1:0]  w_x0 [2];
    logic [DW-1:0]  w_cw [2];
    logic [DW-1:0]  w_y0 [2];
    logic [DW-1:0]  w_ch [2];

    logic           w_adv;
    logic           w_acc;
    logic [XW-1:0]  w_dx [2];
    logic [XW-1:0]  w_dy [2];
    logic           w_hit [2];
    logic           w_sel;
    logic           w_any;

    logic           r_v1;
    logic           r_hit1;
    logic           r_pane1;
    logic [DW-1:0]  r_lx1;
    logic [DW-1:0]  r_ly1;
    logic [DW-1:0]  r_cw1;
    logic [DW-1:0]  r_ch1;

    logic           r_v2;
    logic           r_hit2;
    logic           r_pane2;
    logic [PRW-1:0] r_nx2;
    logic [PRW-1:0] r_ny2;
    logic [DW-1:0]  r_cw2;
    logic [DW-1:0]  r_ch2;

    logic           w_v    [QW+1];
    logic           w_hitp [QW+1];
    logic           w_panep[QW+1];
    logic [PRW-1:0] w_nx   [QW+1];
    logic [QW-1:0]  w_qx   [QW+1];
    logic [DW-1:0]  w_cwp  [QW+1];
    logic [PRW-1:0] w_ny   [QW+1];
    logic [QW-1:0]  w_qy   [QW+1];
    logic [DW-1:0]  w_chp  [QW+1];

    logic                 r_ov;
    logic                 r_oin;
    logic                 r_opane;
    logic [SRC_OUT_W-1:0] r_osx;
    logic [SRC_OUT_W-1:0] r_osy;
    logic [SWD-1:0]       w_flip;

    lnsa_setup #(
        .MAX_SURFACE (MAX_SURFACE),
        .MAX_SOURCE  (MAX_SOURCE),
        .DW          (DW),
        .SWD         (SWD)
    ) u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (w_busy),
        .o_iw        (w_iw),
        .o_ih        (w_ih),
        .o_en        (w_en),
        .o_x0        (w_x0),
        .o_cw        (w_cw),
        .o_y0        (w_y0),
        .o_ch        (w_ch)
    );

    assign w_adv      = !r_ov || i_out_ready;
    assign o_in_ready = w_adv && !w_busy;
    assign w_acc      = i_in_valid && o_in_ready;

    // Pane test: panes never overlap, the right one wins when both claim it
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            w_dx[p]  = XW'(i_out_x) - XW'(w_x0[p]);
            w_dy[p]  = XW'(i_out_y) - XW'(w_y0[p]);
            w_hit[p] = w_en[p]
                    && (XW'(i_out_x) >= XW'(w_x0[p])) && (w_dx[p] < XW'(w_cw[p]))
                    && (XW'(i_out_y) >= XW'(w_y0[p])) && (w_dy[p] < XW'(w_ch[p]));
        end
        w_sel = w_hit[1];
        w_any = w_hit[0] || w_hit[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= w_acc;
            r_v2 <= r_v1;
            r_ov <= w_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hit1  <= w_any;
            r_pane1 <= w_sel;
            r_lx1   <= w_any ? DW'(w_dx[w_sel]) : '0;
            r_ly1   <= w_any ? DW'(w_dy[w_sel]) : '0;
            r_cw1   <= w_cw[w_sel];
            r_ch1   <= w_ch[w_sel];

            r_hit2  <= r_hit1;
            r_pane2 <= r_pane1;
            r_nx2   <= {{SWD{1'b0}}, r_lx1} * {{DW{1'b0}}, w_iw};
            r_ny2   <= {{SWD{1'b0}}, r_ly1} * {{DW{1'b0}}, w_ih};
            r_cw2   <= r_cw1;
            r_ch2   <= r_ch1;
        end
    end

    assign w_v[0]     = r_v2;
    assign w_hitp[0]  = r_hit2;
    assign w_panep[0] = r_pane2;
    assign w_nx[0]    = r_nx2;
    assign w_qx[0]    = '0;
    assign w_cwp[0]   = r_cw2;
    assign w_ny[0]    = r_ny2;
    assign w_qy[0]    = '0;
    assign w_chp[0]   = r_ch2;

    // Most significant quotient bit first
    for (genvar k = 0; k < QW; k++) begin : g_div
        lnsa_divstep #(
            .DW  (DW),
            .PRW (PRW),
            .QW  (QW),
            .BIT (QW - 1 - k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_v     (w_v[k]),
            .i_hit   (w_hitp[k]),
            .i_pane  (w_panep[k]),
            .i_nx    (w_nx[k]),
            .i_qx    (w_qx[k]),
            .i_cw    (w_cwp[k]),
            .i_ny    (w_ny[k]),
            .i_qy    (w_qy[k]),
            .i_ch    (w_chp[k]),
            .o_v     (w_v[k+1]),
            .o_hit   (w_hitp[k+1]),
            .o_pane  (w_panep[k+1]),
            .o_nx    (w_nx[k+1]),
            .o_qx    (w_qx[k+1]),
            .o_cw    (w_cwp[k+1]),
            .o_ny    (w_ny[k+1]),
            .o_qy    (w_qy[k+1]),
            .o_ch    (w_chp[k+1])
        );
    end

    // Source is stored bottom-up
    assign w_flip = w_ih - SWD'(1) - SWD'(w_qy[QW]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_oin   <= w_hitp[QW];
            r_opane <= w_hitp[QW] && w_panep[QW];
            r_osx   <= w_hitp[QW] ? SRC_OUT_W'(w_qx[QW]) : '0;
            r_osy   <= w_hitp[QW] ? SRC_OUT_W'(w_flip) : '0;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_inside_res = r_oin;
    assign o_pane_index = r_opane;
    assign o_src_x      = r_osx;
    assign o_src_y      = r_osy;

    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_inside_res) |->
            (!o_pane_index && (o_src_x == '0) && (o_src_y == '0)))
        else $error("border word carries a nonzero address");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !o_in_ready)
        else $error("word taken while pane geometry is being rebuilt");

    a_enter_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_v1)
        else $error("accepted word did not enter the first stage");

endmodule

// ===== dv/tb.sv =====
// Testbench for the letterbox nearest-neighbour scaler address unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lnsa_pkg::*;

    typedef struct packed {
        logic                 in_img;
        logic                 pane;
        logic [SRC_OUT_W-1:0] sx;
        logic [SRC_OUT_W-1:0] sy;
    } t_addr_word;

    localparam int PIPE_DRAIN = 300;
    localparam longint MAX_SURFACE_C = DEF_MAX_SURFACE;
    localparam longint MAX_SOURCE_C  = DEF_MAX_SOURCE;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [COORD_W-1:0]    i_out_x;
    logic [COORD_W-1:0]    i_out_y;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_inside_res;
    logic                  o_pane_index;
    logic [SRC_OUT_W-1:0]  o_src_x;
    logic [SRC_OUT_W-1:0]  o_src_y;

    // local copy of the register file
    int unsigned surf_w, surf_h, img_w, img_h;
    bit          dual, int_scale;

    t_addr_word  expected_words[$];
    int          n_errors;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          recv_hold_cycles;

    letterbox_nearest_scaler_address DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1ms;
        $display("Test completed with failures");
        $finish;
    end

    // one pane; returns 1 on a hit with source coordinates
    function automatic bit pane_lookup(longint px, longint pw, longint sh, longint iw,
                                       longint ih, longint x, longint y,
                                       output longint sx, output longint sy);
        longint cw, ch, a, b, s, xo, yo, lx, ly;
        cw = pw;
        ch = sh;
        sx = 0;
        sy = 0;
        if (pw <= 0) return 0;
        if (int_scale) begin
            a = cw / iw;
            b = ch / ih;
            s = (a < b) ? a : b;
            if (s >= 1) begin
                cw = iw * s;
                ch = ih * s;
            end
        end else if (cw * ih > ch * iw) begin
            cw = ch * iw / ih;
        end else begin
            ch = cw * ih / iw;
        end
        if (cw <= 0 || ch <= 0) return 0;
        xo = px + (pw - cw) / 2;
        yo = (sh - ch) / 2;
        lx = x - xo;
        ly = y - yo;
        if (lx < 0 || lx >= cw || ly < 0 || ly >= ch) return 0;
        sx = lx * iw / cw;
        sy = ih - 1 - (ly * ih / ch);
        return 1;
    endfunction

    function automatic t_addr_word source_address(int unsigned x, int unsigned y);
        longint     sw, sh, iw, ih, gap, lw, sx, sy;
        t_addr_word w;
        w = '0;
        sw = (surf_w > MAX_SURFACE_C) ? MAX_SURFACE_C : surf_w;
        sh = (surf_h > MAX_SURFACE_C) ? MAX_SURFACE_C : surf_h;
        iw = (img_w > MAX_SOURCE_C) ? MAX_SOURCE_C : img_w;
        ih = (img_h > MAX_SOURCE_C) ? MAX_SOURCE_C : img_h;
        if (sw > 0 && sh > 0 && iw > 0 && ih > 0 && x < sw && y < sh) begin
            if (dual) begin
                if (sw >= 2) begin
                    gap = (sw / GAP_DIV < GAP_MIN) ? GAP_MIN : sw / GAP_DIV;
                    lw = (sw - gap) / 2;
                    if (lw > sw - 1) lw = sw - 1;
                    if (lw < 1) lw = 1;
                    if (pane_lookup(lw + gap, sw - lw - gap, sh, iw, ih, x, y, sx, sy)) begin
                        w = {1'b1, 1'b1, sx[SRC_OUT_W-1:0], sy[SRC_OUT_W-1:0]};
                    end else if (pane_lookup(0, lw, sh, iw, ih, x, y, sx, sy)) begin
                        w = {1'b1, 1'b0, sx[SRC_OUT_W-1:0], sy[SRC_OUT_W-1:0]};
                    end
                end
            end else if (pane_lookup(0, sw, sh, iw, ih, x, y, sx, sy)) begin
                w = {1'b1, 1'b0, sx[SRC_OUT_W-1:0], sy[SRC_OUT_W-1:0]};
            end
        end
        return w;
    endfunction

    // receiver: random stalls, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (recv_hold_cycles > 0) begin
            recv_hold_cycles <= recv_hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_addr_word exp_w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word inside=%0b pane=%0b sx=%0d sy=%0d", $time,
                         o_inside_res, o_pane_index, o_src_x, o_src_y);
                n_errors++;
            end else begin
                exp_w = expected_words.pop_front();
                if (o_inside_res !== exp_w.in_img) begin
                    $display("%0t: inside expected %0b actual %0b", $time, exp_w.in_img,
                             o_inside_res);
                    n_errors++;
                end
                if (o_pane_index !== exp_w.pane) begin
                    $display("%0t: pane expected %0b actual %0b", $time, exp_w.pane,
                             o_pane_index);
                    n_errors++;
                end
                if (o_src_x !== exp_w.sx) begin
                    $display("%0t: src_x expected %0d actual %0d", $time, exp_w.sx, o_src_x);
                    n_errors++;
                end
                if (o_src_y !== exp_w.sy) begin
                    $display("%0t: src_y expected %0d actual %0d", $time, exp_w.sy, o_src_y);
                    n_errors++;
                end
            end
        end
    end

    // valid stays high into the next word unless the sender idles
    task automatic send_coord(int unsigned x, int unsigned y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_out_x    <= x[COORD_W-1:0];
        i_out_y    <= y[COORD_W-1:0];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_words.push_back(source_address(x, y));
    endtask

    task automatic drain_words();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        case (idx)
            REG_SURFACE_WIDTH:  surf_w = val & 32'h7FFF;
            REG_SURFACE_HEIGHT: surf_h = val & 32'h7FFF;
            REG_SOURCE_WIDTH:   img_w = val & 32'h1FFF;
            REG_SOURCE_HEIGHT:  img_h = val & 32'h1FFF;
            REG_DUAL_PANES:     dual = val[0];
            REG_INTEGER_SCALE:  int_scale = val[0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned iw,
                                int unsigned ih, bit dp, bit is);
        drain_words();
        write_reg(REG_SURFACE_WIDTH, sw);
        write_reg(REG_SURFACE_HEIGHT, sh);
        write_reg(REG_SOURCE_WIDTH, iw);
        write_reg(REG_SOURCE_HEIGHT, ih);
        write_reg(REG_DUAL_PANES, 32'(dp));
        write_reg(REG_INTEGER_SCALE, 32'(is));
        i_cfg_we <= 1'b0;
    endtask

    // mostly on-surface coordinates, some anywhere
    task automatic random_coords(int count);
        int unsigned x, y;
        repeat (count) begin
            if ($urandom_range(9) == 0) begin
                x = $urandom_range(16383);
                y = $urandom_range(16383);
            end else begin
                x = $urandom_range((surf_w > 16384 ? 16384 : (surf_w == 0 ? 1 : surf_w)) - 1);
                y = $urandom_range((surf_h > 16384 ? 16384 : (surf_h == 0 ? 1 : surf_h)) - 1);
            end
            send_coord(x, y);
        end
    endtask

    task automatic test_reset_geometry();
        send_coord(0, 0);
        send_coord(80, 0);
        send_coord(80, 479);
        send_coord(559, 240);
        send_coord(560, 240);
        send_coord(639, 479);
        send_coord(640, 0);
        send_coord(16383, 16383);
        random_coords(100);
    endtask

    task automatic test_directed_cases();
        // oversized registers saturate
        set_geometry(32767, 32767, 8191, 8191, 0, 0);
        send_coord(0, 0);
        send_coord(16383, 16383);
        send_coord(8191, 1);
        // zero sizes
        set_geometry(0, 100, 10, 10, 0, 0);
        send_coord(0, 0);
        set_geometry(100, 100, 0, 10, 0, 0);
        send_coord(50, 50);
        // tiny dual surface
        set_geometry(2, 1, 1, 1, 1, 0);
        send_coord(0, 0);
        send_coord(1, 0);
        set_geometry(30, 10, 1, 1, 1, 1);
        send_coord(0, 0);
        send_coord(29, 5);
        // degenerate fit: tall thin source on a wide short surface
        set_geometry(4, 1, 1, 4096, 0, 0);
        send_coord(0, 0);
        send_coord(2, 0);
        // integer factor below one stretches
        set_geometry(100, 50, 200, 100, 0, 1);
        send_coord(0, 0);
        send_coord(99, 49);
        send_coord(50, 25);
    endtask

    task automatic test_random_configs();
        int unsigned sw, sh, iw, ih;
        repeat (12) begin
            case ($urandom_range(3))
                0: begin sw = $urandom_range(2, 64); sh = $urandom_range(1, 64); end
                1: begin sw = $urandom_range(2, 2000); sh = $urandom_range(1, 2000); end
                2: begin sw = $urandom_range(2, 32767); sh = $urandom_range(1, 32767); end
                default: begin sw = $urandom_range(0, 100); sh = $urandom_range(0, 100); end
            endcase
            iw = ($urandom_range(4) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 640);
            ih = ($urandom_range(4) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 480);
            set_geometry(sw, sh, iw, ih, 1'($urandom_range(1)), 1'($urandom_range(1)));
            random_coords(65);
        end
    endtask

    task automatic test_backpressure();
        set_geometry(1920, 1080, 640, 480, 1, 1);
        recv_hold_cycles <= 400;
        random_coords(60);
        drain_words();
        // sender pauses until everything is back
        random_coords(40);
        drain_words();
        set_geometry(640, 480, 320, 240, 0, 0);
        random_coords(40);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_x = '0;
        i_out_y = '0;
        n_errors = 0;
        recv_hold_cycles = 0;
        send_idle_pct = 24;
        recv_idle_pct = 88;
        surf_w = 32'(RST_SURFACE_WIDTH);
        surf_h = 32'(RST_SURFACE_HEIGHT);
        img_w = 32'(RST_SOURCE_WIDTH);
        img_h = 32'(RST_SOURCE_HEIGHT);
        dual = 1'b0;
        int_scale = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_geometry();
        test_directed_cases();
        test_random_configs();
        send_idle_pct = 88;
        recv_idle_pct = 24;
        test_random_configs();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();

        drain_words();
        repeat (PIPE_DRAIN) @(posedge i_clk);
        if (n_errors == 0 && expected_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
